@@ rtl/cawf_pkg.sv @@
package cawf_pkg;

	localparam logic [3:0] ACT_ADD   = 4'd0;
	localparam logic [3:0] ACT_ADC   = 4'd1;
	localparam logic [3:0] ACT_SUB   = 4'd2;
	localparam logic [3:0] ACT_SBC   = 4'd3;
	localparam logic [3:0] ACT_INC8  = 4'd4;
	localparam logic [3:0] ACT_DEC8  = 4'd5;
	localparam logic [3:0] ACT_ADD16 = 4'd6;
	localparam logic [3:0] ACT_INC16 = 4'd7;
	localparam logic [3:0] ACT_DEC16 = 4'd8;
	localparam logic [3:0] ACT_ADDSP = 4'd9;
	localparam logic [3:0] ACT_CCF   = 4'd10;
	localparam logic [3:0] ACT_SCF   = 4'd11;

	typedef struct packed {
		logic [3:0]  action;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result;
		logic        zero_flag;
		logic        subtract_flag;
		logic        half_flag;
		logic        carry_flag;
	} out_item_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

@@ rtl/cawf_alu.sv @@
module cawf_alu (
	input  cawf_pkg::in_item_t  item,
	input  cawf_pkg::flags_t    flags,
	output logic [15:0]         result,
	output cawf_pkg::flags_t    flags_next
);

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic [7:0]  rhs8;
	logic        cin;
	logic [8:0]  add9;
	logic [4:0]  add_nib;
	logic [8:0]  sub9;
	logic [4:0]  sub_nib;
	logic [16:0] add17;
	logic [12:0] add13;
	logic [15:0] sp_sum;
	logic [4:0]  sp_nib;
	logic [8:0]  sp_byte;

	assign a8 = item.operand_a[7:0];
	assign b8 = item.operand_b[7:0];

	// Byte increment and decrement reuse the byte adder and subtractor with a constant one.
	assign rhs8 = (item.action == cawf_pkg::ACT_INC8 || item.action == cawf_pkg::ACT_DEC8)
		? 8'd1 : b8;
	assign cin = (item.action == cawf_pkg::ACT_ADC || item.action == cawf_pkg::ACT_SBC)
		? flags.c : 1'b0;

	assign add9    = {1'b0, a8} + {1'b0, rhs8} + {8'd0, cin};
	assign add_nib = {1'b0, a8[3:0]} + {1'b0, rhs8[3:0]} + {4'd0, cin};
	// The top bit of a one-bit-wider difference is the borrow out.
	assign sub9    = {1'b0, a8} - {1'b0, rhs8} - {8'd0, cin};
	assign sub_nib = {1'b0, a8[3:0]} - {1'b0, rhs8[3:0]} - {4'd0, cin};

	assign add17 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
	assign add13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

	assign sp_sum  = item.operand_a + {{8{b8[7]}}, b8};
	assign sp_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
	assign sp_byte = {1'b0, a8} + {1'b0, b8};

	always_comb begin
		result     = item.operand_a;
		flags_next = flags;
		unique case (item.action) inside
			cawf_pkg::ACT_ADD, cawf_pkg::ACT_ADC, cawf_pkg::ACT_INC8: begin
				result       = {8'd0, add9[7:0]};
				flags_next.z = (add9[7:0] == 8'd0);
				flags_next.n = 1'b0;
				flags_next.h = add_nib[4];
				flags_next.c = (item.action == cawf_pkg::ACT_INC8) ? flags.c : add9[8];
			end
			cawf_pkg::ACT_SUB, cawf_pkg::ACT_SBC, cawf_pkg::ACT_DEC8: begin
				result       = {8'd0, sub9[7:0]};
				flags_next.z = (sub9[7:0] == 8'd0);
				flags_next.n = 1'b1;
				flags_next.h = sub_nib[4];
				flags_next.c = (item.action == cawf_pkg::ACT_DEC8) ? flags.c : sub9[8];
			end
			cawf_pkg::ACT_ADD16: begin
				result       = add17[15:0];
				flags_next.n = 1'b0;
				flags_next.h = add13[12];
				flags_next.c = add17[16];
			end
			cawf_pkg::ACT_INC16: begin
				result = item.operand_a + 16'd1;
			end
			cawf_pkg::ACT_DEC16: begin
				result = item.operand_a - 16'd1;
			end
			cawf_pkg::ACT_ADDSP: begin
				result       = sp_sum;
				flags_next.z = 1'b0;
				flags_next.n = 1'b0;
				flags_next.h = sp_nib[4];
				flags_next.c = sp_byte[8];
			end
			cawf_pkg::ACT_CCF: begin
				flags_next.n = 1'b0;
				flags_next.h = 1'b0;
				flags_next.c = ~flags.c;
			end
			cawf_pkg::ACT_SCF: begin
				flags_next.n = 1'b0;
				flags_next.h = 1'b0;
				flags_next.c = 1'b1;
			end
			default: begin
				// Unassigned codes pass operand_a through and keep the flags.
				result     = item.operand_a;
				flags_next = flags;
			end
		endcase
	end

endmodule

@@ rtl/cpu_alu_with_flags.sv @@
// Arithmetic unit of an 8-bit CPU with a stored Z/N/H/C flag register.
// Input channel: in_valid/in_ready carry one beat of in_data (action and
// two 16-bit operands). Output channel: out_valid/out_ready carry one beat
// of out_data (16-bit result and the four flags after the operation).
// Every input beat yields exactly one output beat, in order.
// An accepted beat sits in the input register, the operation and flag logic
// run between that register and the output register, and the result is
// offered from the output register.
// Throughput is one beat per cycle unless out_ready stalls; the flag register
// is written as a beat moves into the output register, so the next beat sees
// the new carry. When the receiver stalls, the output register holds its beat
// and the input register takes one more; in_ready then drops until out_ready
// returns. Reset clears both valid bits and the flag register to all zero.
module cpu_alu_with_flags (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cawf_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cawf_pkg::out_item_t  out_data
);

	logic                 valid_s1;
	cawf_pkg::in_item_t   item_s1;
	logic                 valid_q;
	cawf_pkg::out_item_t  out_q;
	cawf_pkg::flags_t     flags_q;
	logic [15:0]          alu_result;
	cawf_pkg::flags_t     alu_flags;
	logic                 advance;

	cawf_alu u_alu (
		.item       (item_s1),
		.flags      (flags_q),
		.result     (alu_result),
		.flags_next (alu_flags)
	);

	assign advance  = valid_s1 && (!valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_q <= 1'b1;
				flags_q <= alu_flags;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q.result        <= alu_result;
			out_q.zero_flag     <= alu_flags.z;
			out_q.subtract_flag <= alu_flags.n;
			out_q.half_flag     <= alu_flags.h;
			out_q.carry_flag    <= alu_flags.c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q))
		else $error("flag register changed without a beat moving to the output");

	a_flags_match_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_q.zero_flag == flags_q.z && out_q.subtract_flag == flags_q.n &&
			out_q.half_flag == flags_q.h && out_q.carry_flag == flags_q.c))
		else $error("output flags differ from the stored flag register");

	a_wide_step_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.action == cawf_pkg::ACT_INC16 ||
			item_s1.action == cawf_pkg::ACT_DEC16) |=> flags_q == $past(flags_q))
		else $error("16-bit increment or decrement altered the flags");
`endif

endmodule
